// ===== src/sprite_quad_batcher_macros.svh =====
// assertion helpers shared by the sprite quad batcher modules
`ifndef SPRITE_QUAD_BATCHER_MACROS_SVH
`define SPRITE_QUAD_BATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define SQB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SQB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SQB_ASSERT(lbl, prop, msg)
`define SQB_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== src/sqb_pkg.sv =====
package sqb_pkg;

  localparam int unsigned MAX_SLOTS   = 32;
  localparam int unsigned MAX_QUADS   = 16384;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic KIND_VERT = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;

  typedef struct packed {
    logic        has_flush;
    logic [4:0]  flush_slot;
    logic [16:0] flush_idx;
    logic        has_quad;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [30:0] size_x;
    logic [30:0] size_y;
    logic [15:0] rotation;
    logic [31:0] color;
    logic [4:0]  slot;
    logic [15:0] tiling;
  } sqb_cmd_t;

endpackage

// ===== src/sqb_queue.sv =====
`include "sprite_quad_batcher_macros.svh"

module sqb_queue #(
  parameter int unsigned Depth = sqb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sqb_pkg::sqb_cmd_t din,
  input  logic             pop,
  output sqb_pkg::sqb_cmd_t dout,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sqb_pkg::sqb_cmd_t mem_r [Depth];
  logic [PtrW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CntW'(Depth));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  `SQB_ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
  `SQB_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ===== src/sqb_front.sv =====
`include "sprite_quad_batcher_macros.svh"

module sqb_front #(
  parameter int unsigned MaxSlots = sqb_pkg::MAX_SLOTS,
  parameter int unsigned MaxQuads = sqb_pkg::MAX_QUADS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [14:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_pos_x,
  input  logic [31:0]       in_pos_y,
  input  logic [31:0]       in_pos_z,
  input  logic [30:0]       in_size_x,
  input  logic [30:0]       in_size_y,
  input  logic [15:0]       in_rotation,
  input  logic [31:0]       in_color,
  input  logic [15:0]       in_texture_id,
  input  logic [15:0]       in_tiling,
  output logic              q_push,
  output sqb_pkg::sqb_cmd_t q_din,
  input  logic              q_full
);

  localparam int unsigned SlW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned SuW = $clog2(MaxSlots + 1);
  localparam int unsigned QcW = $clog2(MaxQuads + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOOK = 3'b010,
    F_DEC  = 3'b100
  } fst_t;

  fst_t fst_r, fst_nxt;
  logic [14:0] cfg_r;
  logic [1:0]  act_r;
  logic [15:0] tex_r;
  sqb_pkg::sqb_cmd_t item_r;
  logic [15:0] tab_r [MaxSlots];
  logic [MaxSlots-1:0] match_r, match_nxt;
  logic [SuW-1:0] su_r, su_nxt;
  logic [QcW-1:0] qc_r, qc_nxt;

  logic [SlW-1:0] hit_idx, slot_v;
  logic found, batch_full, flush, add, commit, push_req;
  logic [14:0] lim;
  logic [QcW-1:0] qc_e, fl_qc;
  logic [SuW-1:0] su_e, fl_su;

  assign in_stall = (fst_r != F_IDLE);

  always_comb begin
    for (int i = 0; i < MaxSlots; i++) begin
      match_nxt[i] = (i != 0) && (SuW'(i) < su_r) && (tab_r[i] == tex_r);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = MaxSlots - 1; i >= 1; i--) begin
      if (match_r[i]) hit_idx = SlW'(i);
    end
  end
  assign found = |match_r;

  always_comb begin
    if (cfg_r == '0) begin
      lim = 15'd1;
    end else if (cfg_r > 15'(MaxQuads)) begin
      lim = 15'(MaxQuads);
    end else begin
      lim = cfg_r;
    end
  end
  assign batch_full = (15'(qc_r) >= lim);

  always_comb begin
    flush    = 1'b0;
    fl_qc    = qc_r;
    fl_su    = su_r;
    qc_e     = batch_full ? '0 : qc_r;
    su_e     = batch_full ? SuW'(1) : su_r;
    slot_v   = '0;
    add      = 1'b0;
    push_req = 1'b0;
    qc_nxt   = qc_r;
    su_nxt   = su_r;
    if (fst_r == F_DEC) begin
      unique case (act_r)
        sqb_pkg::ACT_DRAW: begin
          flush  = batch_full;
          su_nxt = su_e;
          if (tex_r != '0) begin
            if (!batch_full && found) begin
              slot_v = hit_idx;
            end else if (su_e == SuW'(MaxSlots)) begin
              flush  = 1'b1;
              fl_qc  = qc_e;
              fl_su  = su_e;
              slot_v = SlW'(1);
              su_nxt = SuW'(2);
              add    = 1'b1;
            end else begin
              slot_v = su_e[SlW-1:0];
              su_nxt = su_e + 1'b1;
              add    = 1'b1;
            end
          end
          qc_e     = (flush && !batch_full) ? '0 : qc_e;
          qc_nxt   = qc_e + 1'b1;
          push_req = 1'b1;
        end
        sqb_pkg::ACT_END: begin
          flush    = (qc_r != '0);
          push_req = flush;
          qc_nxt   = '0;
          su_nxt   = SuW'(1);
        end
        sqb_pkg::ACT_BEGIN: begin
          qc_nxt = '0;
          su_nxt = SuW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    q_din            = item_r;
    q_din.has_flush  = flush;
    q_din.flush_slot = 5'(fl_su - 1'b1);
    q_din.flush_idx  = 17'({fl_qc, 2'b00}) + 17'({fl_qc, 1'b0});
    q_din.has_quad   = (act_r == sqb_pkg::ACT_DRAW);
    q_din.slot       = 5'(slot_v);
  end

  assign q_push = push_req && !q_full;
  assign commit = (fst_r == F_DEC) && !(push_req && q_full);

  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE:  if (in_valid) fst_nxt = F_LOOK;
      F_LOOK:  fst_nxt = F_DEC;
      F_DEC:   if (commit) fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      cfg_r <= 15'(MaxQuads);
      su_r  <= SuW'(1);
      qc_r  <= '0;
    end else begin
      fst_r <= fst_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (commit) begin
        su_r <= su_nxt;
        qc_r <= qc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fst_r == F_IDLE && in_valid) begin
      act_r             <= in_action;
      tex_r             <= in_texture_id;
      item_r.has_flush  <= 1'b0;
      item_r.flush_slot <= '0;
      item_r.flush_idx  <= '0;
      item_r.has_quad   <= 1'b0;
      item_r.pos_x      <= in_pos_x;
      item_r.pos_y      <= in_pos_y;
      item_r.pos_z      <= in_pos_z;
      item_r.size_x     <= in_size_x;
      item_r.size_y     <= in_size_y;
      item_r.rotation   <= in_rotation;
      item_r.color      <= in_color;
      item_r.slot       <= '0;
      item_r.tiling     <= in_tiling;
    end
    if (fst_r == F_LOOK) match_r <= match_nxt;
    if (commit && add) tab_r[slot_v] <= tex_r;
  end

  `SQB_ASSERT(a_slots_range, (su_r >= SuW'(1)) && (su_r <= SuW'(MaxSlots)), "slots in use out of range")
  `SQB_ASSERT(a_quads_range, 15'(qc_r) <= 15'(MaxQuads), "quad count above limit")

endmodule

// ===== src/sqb_back.sv =====
`include "sprite_quad_batcher_macros.svh"

module sqb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sqb_pkg::sqb_cmd_t q_dout,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [31:0]       out_vert_x,
  output logic [31:0]       out_vert_y,
  output logic [31:0]       out_vert_z,
  output logic [31:0]       out_vert_color,
  output logic              out_tex_u,
  output logic              out_tex_v,
  output logic [4:0]        out_slot,
  output logic [15:0]       out_vert_tiling,
  output logic [16:0]       out_index_count,
  output logic              out_last
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_DRAW = 6'b000010,
    B_TRIG = 6'b000100,
    B_PROD = 6'b001000,
    B_SUM  = 6'b010000,
    B_CORN = 6'b100000
  } bst_t;

  bst_t bst_r, bst_nxt;
  logic emit_r;
  logic [2:0] step_r;
  logic [1:0] k_r;
  sqb_pkg::sqb_cmd_t cmd_r;
  logic neg_r [2];
  logic [30:0] t_r [2];
  logic [30:0] t2_r [2];
  logic [31:0] p_r [2];
  logic [31:0] mag_r [2];
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [63:0] s1_r, s2_r, t1_r, tt2_r;
  logic signed [32:0] rx_r, ry_r;

  logic [31:0] op_a [2];
  logic [31:0] op_b [2];
  logic [63:0] prod [2];
  logic signed [63:0] sprod [2];
  logic out_free, load_draw, load_vert;
  logic [15:0] rot_c;
  logic [13:0] r_s, r_c;
  logic [14:0] u_s, u_c;
  logic signed [63:0] sx_n, sy_n;
  logic signed [33:0] vx, vy;

  assign out_free = !out_valid || !out_stall;

  assign rot_c = q_dout.rotation + 16'd16384;
  assign r_s   = q_dout.rotation[13:0];
  assign r_c   = rot_c[13:0];
  assign u_s   = q_dout.rotation[14] ? 15'd16384 - 15'(r_s) : 15'(r_s);
  assign u_c   = rot_c[14] ? 15'd16384 - 15'(r_c) : 15'(r_c);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      op_a[l] = {1'b0, t_r[l]};
      op_b[l] = {1'b0, t_r[l]};
      if (bst_r == B_TRIG) begin
        unique case (step_r)
          3'd0: begin
            op_a[l] = {1'b0, t_r[l]};
            op_b[l] = {1'b0, t_r[l]};
          end
          3'd1: begin
            op_a[l] = {1'b0, t2_r[l]};
            op_b[l] = sqb_pkg::C7;
          end
          3'd2, 3'd3: begin
            op_a[l] = {1'b0, t2_r[l]};
            op_b[l] = p_r[l];
          end
          default: begin
            op_a[l] = {1'b0, t_r[l]};
            op_b[l] = p_r[l];
          end
        endcase
      end else begin
        op_a[l] = (step_r[0] ^ (l == 1)) ? mag_r[0] : mag_r[1];
        op_b[l] = (l == 0) ? {1'b0, cmd_r.size_x} : {1'b0, cmd_r.size_y};
      end
      prod[l]  = op_a[l] * op_b[l];
      sprod[l] = $signed({1'b0, prod[l][62:0]});
    end
  end

  // corner order (-,-) (+,-) (+,+) (-,+)
  always_comb begin
    unique case (k_r)
      2'd0: begin
        sx_n = -s2_r;
        sy_n = -t1_r;
      end
      2'd1: begin
        sx_n = s1_r;
        sy_n = tt2_r;
      end
      2'd2: begin
        sx_n = s2_r;
        sy_n = t1_r;
      end
      default: begin
        sx_n = -s1_r;
        sy_n = -tt2_r;
      end
    endcase
  end

  assign vx = 34'($signed(cmd_r.pos_x)) + 34'(rx_r);
  assign vy = 34'($signed(cmd_r.pos_y)) + 34'(ry_r);

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      res = v[31:0];
    end else if (v[33]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

  assign q_pop     = (bst_r == B_IDLE) && !q_empty;
  assign load_draw = (bst_r == B_DRAW) && out_free;
  assign load_vert = (bst_r == B_CORN) && emit_r && out_free;

  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_IDLE: if (!q_empty) bst_nxt = q_dout.has_flush ? B_DRAW : B_TRIG;
      B_DRAW: if (out_free) bst_nxt = cmd_r.has_quad ? B_TRIG : B_IDLE;
      B_TRIG: if (step_r == 3'd4) bst_nxt = B_PROD;
      B_PROD: if (step_r == 3'd1) bst_nxt = B_SUM;
      B_SUM:  bst_nxt = B_CORN;
      B_CORN: if (load_vert && k_r == 2'd3) bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r     <= B_IDLE;
      out_valid <= 1'b0;
      step_r    <= '0;
      k_r       <= '0;
      emit_r    <= 1'b0;
    end else begin
      bst_r <= bst_nxt;
      if (load_draw || load_vert) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (bst_r != bst_nxt) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
      if (bst_r == B_SUM) begin
        k_r    <= '0;
        emit_r <= 1'b0;
      end else if (bst_r == B_CORN) begin
        if (!emit_r) begin
          emit_r <= 1'b1;
        end else if (load_vert) begin
          emit_r <= 1'b0;
          k_r    <= k_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r    <= q_dout;
      t_r[0]   <= {u_s, 16'b0};
      t_r[1]   <= {u_c, 16'b0};
      neg_r[0] <= q_dout.rotation[15];
      neg_r[1] <= rot_c[15];
    end
    if (bst_r == B_TRIG) begin
      for (int l = 0; l < 2; l++) begin
        unique case (step_r)
          3'd0: t2_r[l] <= prod[l][60:30];
          3'd1: p_r[l] <= sqb_pkg::C5 - prod[l][61:30];
          3'd2: p_r[l] <= sqb_pkg::C3 - prod[l][61:30];
          3'd3: p_r[l] <= sqb_pkg::C1 - prod[l][61:30];
          default: mag_r[l] <= prod[l][61:30];
        endcase
      end
    end
    if (bst_r == B_PROD) begin
      if (step_r[0] == 1'b0) begin
        pa_r <= neg_r[1] ? -sprod[0] : sprod[0];
        pb_r <= neg_r[0] ? -sprod[1] : sprod[1];
      end else begin
        pc_r <= neg_r[0] ? -sprod[0] : sprod[0];
        pd_r <= neg_r[1] ? -sprod[1] : sprod[1];
      end
    end
    if (bst_r == B_SUM) begin
      s1_r  <= pa_r + pb_r;
      s2_r  <= pa_r - pb_r;
      t1_r  <= pc_r + pd_r;
      tt2_r <= pc_r - pd_r;
    end
    if (bst_r == B_CORN && !emit_r) begin
      rx_r <= 33'(sx_n >>> 31);
      ry_r <= 33'(sy_n >>> 31);
    end
    if (load_draw) begin
      out_kind        <= sqb_pkg::KIND_DRAW;
      out_vert_x      <= '0;
      out_vert_y      <= '0;
      out_vert_z      <= '0;
      out_vert_color  <= '0;
      out_tex_u       <= 1'b0;
      out_tex_v       <= 1'b0;
      out_slot        <= cmd_r.flush_slot;
      out_vert_tiling <= '0;
      out_index_count <= cmd_r.flush_idx;
      out_last        <= !cmd_r.has_quad;
    end else if (load_vert) begin
      out_kind        <= sqb_pkg::KIND_VERT;
      out_vert_x      <= sat32(vx);
      out_vert_y      <= sat32(vy);
      out_vert_z      <= cmd_r.pos_z;
      out_vert_color  <= cmd_r.color;
      out_tex_u       <= k_r[0] ^ k_r[1];
      out_tex_v       <= k_r[1];
      out_slot        <= cmd_r.slot;
      out_vert_tiling <= cmd_r.tiling;
      out_index_count <= '0;
      out_last        <= (k_r == 2'd3);
    end
  end

  `SQB_ASSERT_IMPL(a_draw_has_quads, out_valid && out_kind == sqb_pkg::KIND_DRAW,
                   out_index_count != '0, "draw call with empty batch")
  `SQB_ASSERT_IMPL(a_pop_idle, q_pop, bst_r == B_IDLE && !emit_r, "pop while busy")

endmodule

// ===== src/sprite_quad_batcher.sv =====
// Sprite quad batcher. Items are begin scene, end scene and draw quad; a draw quad
// gets a texture slot (texture 0 is the white texture in slot 0) and yields four
// vertex records, preceded by a draw call when the batch or the slot table is full;
// end scene yields a draw call when quads are pending. The front end takes items one
// at a time through capture, parallel slot compare and decide, holding in decide while
// the queue is full, and hands work through a two-entry queue. The back end computes
// sine and cosine with two shared 32x32 multipliers over 5 steps, forms the scaled
// products in 2 more, then per corner computes the offset and emits the vertex record,
// waiting while the output stalls; the back end's multiplier sequence sets the sustained rate.
module sprite_quad_batcher #(
  parameter int unsigned MAX_SLOTS = sqb_pkg::MAX_SLOTS,
  parameter int unsigned MAX_QUADS = sqb_pkg::MAX_QUADS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [30:0] in_size_x,
  input  logic [30:0] in_size_y,
  input  logic [15:0] in_rotation,
  input  logic [31:0] in_color,
  input  logic [15:0] in_texture_id,
  input  logic [15:0] in_tiling,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_vert_x,
  output logic [31:0] out_vert_y,
  output logic [31:0] out_vert_z,
  output logic [31:0] out_vert_color,
  output logic        out_tex_u,
  output logic        out_tex_v,
  output logic [4:0]  out_slot,
  output logic [15:0] out_vert_tiling,
  output logic [16:0] out_index_count,
  output logic        out_last
);

  sqb_pkg::sqb_cmd_t q_din, q_dout;
  logic q_push, q_pop, q_full, q_empty;

  sqb_front #(
    .MaxSlots (MAX_SLOTS),
    .MaxQuads (MAX_QUADS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_size_x     (in_size_x),
    .in_size_y     (in_size_y),
    .in_rotation   (in_rotation),
    .in_color      (in_color),
    .in_texture_id (in_texture_id),
    .in_tiling     (in_tiling),
    .q_push        (q_push),
    .q_din         (q_din),
    .q_full        (q_full)
  );

  sqb_queue #(
    .Depth (sqb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  sqb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_dout          (q_dout),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_vert_color  (out_vert_color),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_slot        (out_slot),
    .out_vert_tiling (out_vert_tiling),
    .out_index_count (out_index_count),
    .out_last        (out_last)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [30:0] size_x;
    logic [30:0] size_y;
    logic [15:0] rotation;
    logic [31:0] color;
    logic [15:0] texture_id;
    logic [15:0] tiling;
  } quad_req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] vert_x;
    logic [31:0] vert_y;
    logic [31:0] vert_z;
    logic [31:0] vert_color;
    logic        tex_u;
    logic        tex_v;
    logic [4:0]  slot;
    logic [15:0] vert_tiling;
    logic [16:0] index_count;
    logic        last;
  } vertex_rec_t;

  localparam longint unsigned POLY_C1 = 64'd1686629713;
  localparam longint unsigned POLY_C3 = 64'd693598668;
  localparam longint unsigned POLY_C5 = 64'd85569306;
  localparam longint unsigned POLY_C7 = 64'd5026995;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  quad_req_t   in_req;
  logic        out_valid;
  logic        out_stall;
  vertex_rec_t out_rec;

  sprite_quad_batcher u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_req.action), .in_pos_x(in_req.pos_x), .in_pos_y(in_req.pos_y),
    .in_pos_z(in_req.pos_z), .in_size_x(in_req.size_x), .in_size_y(in_req.size_y),
    .in_rotation(in_req.rotation), .in_color(in_req.color),
    .in_texture_id(in_req.texture_id), .in_tiling(in_req.tiling),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_rec.kind), .out_vert_x(out_rec.vert_x), .out_vert_y(out_rec.vert_y),
    .out_vert_z(out_rec.vert_z), .out_vert_color(out_rec.vert_color),
    .out_tex_u(out_rec.tex_u), .out_tex_v(out_rec.tex_v), .out_slot(out_rec.slot),
    .out_vert_tiling(out_rec.vert_tiling), .out_index_count(out_rec.index_count),
    .out_last(out_rec.last)
  );

  quad_req_t   pending_reqs[$];
  vertex_rec_t expected_recs[$];
  logic [15:0] tex_slots[sqb_pkg::MAX_SLOTS];
  int unsigned slots_in_use;
  int unsigned batch_quads;
  int unsigned batch_limit_reg;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          error_count;
  int          cycle_count;
  logic        req_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sin_of_turn(logic [15:0] a);
    longint unsigned t, t2, p, s;
    logic [13:0] r;
    r = a[13:0];
    t = (a[14] ? (64'd16384 - r) : longint'(r)) << 16;
    t2 = (t * t) >> 30;
    p = POLY_C5 - ((t2 * POLY_C7) >> 30);
    p = POLY_C3 - ((t2 * p) >> 30);
    p = POLY_C1 - ((t2 * p) >> 30);
    s = (t * p) >> 30;
    return a[15] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [31:0] sat_add(longint base, longint delta);
    longint v;
    v = base + delta;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic flush_batch(ref vertex_rec_t recs[$]);
    vertex_rec_t d;
    if (batch_quads > 0) begin
      d = '0;
      d.kind = sqb_pkg::KIND_DRAW;
      d.slot = 5'(slots_in_use - 1);
      d.index_count = 17'(batch_quads * 6);
      recs.push_back(d);
    end
    batch_quads = 0;
    slots_in_use = 1;
  endtask

  task automatic predict_vertices(quad_req_t q);
    vertex_rec_t recs[$];
    vertex_rec_t v;
    int unsigned lim, slot_no;
    longint sn, cs, lx, ly, rx, ry;
    int cx, cy;
    if (q.action == sqb_pkg::ACT_BEGIN) begin
      batch_quads = 0;
      slots_in_use = 1;
    end else if (q.action == sqb_pkg::ACT_END) begin
      flush_batch(recs);
    end else if (q.action == sqb_pkg::ACT_DRAW) begin
      lim = batch_limit_reg;
      if (lim < 1) lim = 1;
      if (lim > sqb_pkg::MAX_QUADS) lim = sqb_pkg::MAX_QUADS;
      if (batch_quads >= lim) flush_batch(recs);
      slot_no = 0;
      if (q.texture_id != 0) begin
        for (int i = 1; i < slots_in_use && i < sqb_pkg::MAX_SLOTS; i++) begin
          if (slot_no == 0 && tex_slots[i] == q.texture_id) slot_no = i;
        end
        if (slot_no == 0) begin
          if (slots_in_use >= sqb_pkg::MAX_SLOTS) flush_batch(recs);
          slot_no = slots_in_use;
          tex_slots[slot_no % sqb_pkg::MAX_SLOTS] = q.texture_id;
          slots_in_use++;
        end
      end
      sn = sin_of_turn(q.rotation);
      cs = sin_of_turn(q.rotation + 16'd16384);
      for (int c = 0; c < 4; c++) begin
        cx = (c == 1 || c == 2) ? 1 : -1;
        cy = (c >= 2) ? 1 : -1;
        lx = longint'(q.size_x) * cx;
        ly = longint'(q.size_y) * cy;
        rx = (cs * lx - sn * ly) >>> 31;
        ry = (sn * lx + cs * ly) >>> 31;
        v = '0;
        v.kind = sqb_pkg::KIND_VERT;
        v.vert_x = sat_add(longint'($signed(q.pos_x)), rx);
        v.vert_y = sat_add(longint'($signed(q.pos_y)), ry);
        v.vert_z = q.pos_z;
        v.vert_color = q.color;
        v.tex_u = (c == 1 || c == 2);
        v.tex_v = (c >= 2);
        v.slot = 5'(slot_no);
        v.vert_tiling = q.tiling;
        recs.push_back(v);
      end
      batch_quads++;
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) expected_recs.push_back(recs[i]);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && in_valid && !req_taken) begin
    end else if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_req <= pending_reqs.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_vertices(in_req);
  end

  // receiver
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    vertex_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_recs.size() == 0) begin
        $error("unexpected result: kind %0d", out_rec.kind);
        error_count++;
      end else begin
        e = expected_recs.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_rec.kind));
        check_field("vert_x", e.vert_x, out_rec.vert_x);
        check_field("vert_y", e.vert_y, out_rec.vert_y);
        check_field("vert_z", e.vert_z, out_rec.vert_z);
        check_field("vert_color", e.vert_color, out_rec.vert_color);
        check_field("tex_u", 32'(e.tex_u), 32'(out_rec.tex_u));
        check_field("tex_v", 32'(e.tex_v), 32'(out_rec.tex_v));
        check_field("slot", 32'(e.slot), 32'(out_rec.slot));
        check_field("vert_tiling", 32'(e.vert_tiling), 32'(out_rec.vert_tiling));
        check_field("index_count", 32'(e.index_count), 32'(out_rec.index_count));
        check_field("last", 32'(e.last), 32'(out_rec.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sprite_quad_batcher verification failed");
      $finish;
    end
  end

  function automatic quad_req_t make_req(logic [1:0] act, logic [15:0] tex);
    quad_req_t q;
    q.action = act;
    q.pos_x = $urandom;
    q.pos_y = $urandom;
    q.pos_z = $urandom;
    q.size_x = 31'($urandom);
    q.size_y = 31'($urandom);
    q.rotation = 16'($urandom);
    q.color = $urandom;
    q.texture_id = tex;
    q.tiling = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      q.pos_x = 32'($signed($urandom_range(2000000)) - 1000000);
      q.pos_y = 32'($signed($urandom_range(2000000)) - 1000000);
      q.size_x = 31'($urandom_range(600000));
      q.size_y = 31'($urandom_range(600000));
    end
    return q;
  endfunction

  function automatic logic [15:0] pick_tex();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic write_limit(logic [14:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    batch_limit_reg = 32'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_recs.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_random(int n, bit slot_fill);
    int base, k, added;
    added = 0;
    if (slot_fill) begin
      base = $urandom_range(1, 60000);
      pending_reqs.push_back(make_req(sqb_pkg::ACT_BEGIN, 16'd0));
      for (int i = 0; i < 34; i++) begin
        pending_reqs.push_back(make_req(sqb_pkg::ACT_DRAW, 16'(base + i)));
      end
      pending_reqs.push_back(make_req(sqb_pkg::ACT_END, 16'd0));
      added = 36;
    end
    while (added < n) begin
      if ($urandom_range(9) < 8) begin
        k = $urandom_range(1, 8);
        pending_reqs.push_back(make_req(sqb_pkg::ACT_BEGIN, 16'd0));
        for (int i = 0; i < k; i++) begin
          pending_reqs.push_back(make_req(sqb_pkg::ACT_DRAW, pick_tex()));
        end
        if ($urandom_range(3) != 0) pending_reqs.push_back(make_req(sqb_pkg::ACT_END, 16'd0));
        added += k + 2;
      end else begin
        pending_reqs.push_back(make_req(2'($urandom_range(3)), pick_tex()));
        added++;
      end
    end
  endtask

  initial begin
    quad_req_t q;
    logic [15:0] rots[5];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    req_taken = 1'b0;
    hold_off_cycles = 0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 16;
    recv_idle_pct = 59;
    slots_in_use = 1;
    batch_quads = 0;
    batch_limit_reg = sqb_pkg::MAX_QUADS;
    foreach (tex_slots[i]) tex_slots[i] = '0;
    rots = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_limit(15'd16384);

    // directed: extremes, every action, white texture, ignored action
    pending_reqs.push_back(make_req(sqb_pkg::ACT_END, 16'd0));
    pending_reqs.push_back(make_req(sqb_pkg::ACT_BEGIN, 16'd0));
    foreach (rots[i]) begin
      q = make_req(sqb_pkg::ACT_DRAW, i[0] ? 16'hFFFF : 16'd0);
      q.rotation = rots[i];
      q.pos_x = i[0] ? 32'h7FFFFFFF : 32'h80000000;
      q.pos_y = i[1] ? 32'h80000000 : 32'h7FFFFFFF;
      q.pos_z = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
      q.size_x = i[0] ? 31'h7FFFFFFF : 31'd0;
      q.size_y = i[1] ? 31'd0 : 31'h7FFFFFFF;
      q.color = i[0] ? 32'hFFFFFFFF : 32'd0;
      q.tiling = i[0] ? 16'hFFFF : 16'd0;
      pending_reqs.push_back(q);
    end
    pending_reqs.push_back(make_req(ACT_UNUSED, 16'd7));
    pending_reqs.push_back(make_req(sqb_pkg::ACT_DRAW, 16'hFFFF));
    pending_reqs.push_back(make_req(sqb_pkg::ACT_DRAW, 16'd0));
    pending_reqs.push_back(make_req(sqb_pkg::ACT_END, 16'd0));
    pending_reqs.push_back(make_req(sqb_pkg::ACT_END, 16'd0));
    wait_drained();

    // long receiver hold-off so the input side backs up
    hold_off_cycles = 400;
    add_random(40, 1'b1);
    wait_drained();

    write_limit(15'd3);
    add_random(30, 1'b0);
    wait_drained();

    send_idle_pct = 59;
    recv_idle_pct = 16;
    write_limit(15'd0);
    add_random(25, 1'b0);
    wait_drained();

    // limit set above the maximum: leave a scene open first
    write_limit(15'd32767);
    for (int i = 0; i < 5; i++) pending_reqs.push_back(make_req(sqb_pkg::ACT_DRAW, pick_tex()));
    add_random(20, 1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(15'd1);
    add_random(25, 1'b0);
    wait_drained();

    if (error_count == 0) begin
      $display("sprite_quad_batcher verification clean");
    end else begin
      $display("sprite_quad_batcher verification failed");
    end
    $finish;
  end

endmodule
